>>> rtl/urc_pkg.sv
// urc_pkg: shared types and constants of the ultrasonic range conditioner
// no dependencies; imported by ultrasonic_range_conditioner

package urc_pkg;

   // field widths
   localparam int ECHO_W     = 20;
   localparam int TIME_W     = 32;
   localparam int DIST_W     = 18;
   localparam int CSR_DATA_W = 16;
   localparam int WIN_LEN_W  = 5;

   // default moving average depth
   localparam int MAX_WINDOW_DEF = 16;

   // echo * 17 is at most 25 bits; floor(x / 100) == (x * ceil(2^32 / 100)) >> 32
   localparam int                  SCALED_W    = ECHO_W + 5;
   localparam int                  RECIP_W     = 26;
   localparam int                  RECIP_SHIFT = 32;
   localparam logic [RECIP_W-1:0]  RECIP_100   = 26'd42949673;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] MIN_DIST_RST    = 16'd0;
   localparam logic [CSR_DATA_W-1:0] MAX_DIST_RST    = 16'd4000;
   localparam logic [CSR_DATA_W-1:0] HOLD_WINDOW_RST = 16'd100;
   localparam logic [WIN_LEN_W-1:0]  WIN_LEN_RST     = 5'd4;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MIN_DIST    = 2'd0,
      CSR_MAX_DIST    = 2'd1,
      CSR_HOLD_WINDOW = 2'd2,
      CSR_WIN_LEN     = 2'd3
   } csr_index_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATE,
      ST_DIVIDE
   } state_type;

   // input beat
   typedef struct packed {
      logic [ECHO_W-1:0] echo_us;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   // result beat
   typedef struct packed {
      logic [DIST_W-1:0] distance_mm;
      logic              trigger;
   } rsp_type;

endpackage

>>> rtl/ultrasonic_range_conditioner.sv
// ultrasonic_range_conditioner: echo-to-distance conversion, range gating with
// hold timer, and moving average over a window memory; depends on urc_pkg
//
// Usage:
//   req channel (req_valid / req_stall / req_data) takes one finished echo
//   measurement with its millisecond time stamp per beat. rsp channel
//   (rsp_valid / rsp_stall / rsp_data) returns exactly one beat per input
//   beat: the averaged distance in millimetres and the trigger flag.
//   csr_we / csr_index / csr_wdata write the four limit and window registers;
//   write them only while no beat is in flight.
// Flow:
//   an accepted beat passes the gating and window update step (ST_GATE), then
//   the bit-serial average divider, one quotient bit per step over the SUM_W-bit
//   sum (SUM_W = 18 + clog2(MAX_WINDOW), 22 by default), then the output register.
//   A new beat is accepted only after the previous one is loaded into it.
// Reset: synchronous; registers take their reset values, history and average
//   window are empty, window memory contents are left as they are.
// Stall: a finished result waits in the output register while rsp_stall is
//   high; the next beat is accepted meanwhile, and its result waits at the end
//   of the divider until the output register frees up.

module ultrasonic_range_conditioner #(
   parameter int MAX_WINDOW = urc_pkg::MAX_WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  urc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output urc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  urc_pkg::csr_index_type           csr_index,
   input  logic [urc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import urc_pkg::*;

   localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int FILL_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = DIST_W + $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(SUM_W + 1);
   localparam int IDX_W  = PTR_W + 2;
   localparam int PROD_W = SCALED_W + RECIP_W;

   // sequencer
   state_type state_ff, state_in;
   logic      accept, gate_en, div_busy, div_done, out_free, out_load;

   // configuration registers
   logic [CSR_DATA_W-1:0] min_dist_ff, min_dist_in;
   logic [CSR_DATA_W-1:0] max_dist_ff, max_dist_in;
   logic [CSR_DATA_W-1:0] hold_win_ff, hold_win_in;
   logic [WIN_LEN_W-1:0]  win_len_ff, win_len_in;

   // item registers
   logic [DIST_W-1:0] raw_ff, raw_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // history
   logic [DIST_W-1:0] prev_raw_ff, prev_raw_in;
   logic [TIME_W-1:0] hold_start_ff, hold_start_in;
   logic [DIST_W-1:0] prev_out_ff, prev_out_in;
   logic              trig_ff, trig_in;

   // window bookkeeping
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   // divider
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [FILL_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // window memory
   logic [DIST_W-1:0] window_mem [MAX_WINDOW];
   logic [DIST_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]  rd_addr;
   logic [DIST_W-1:0] gated;

   // combinational helpers
   logic [SCALED_W-1:0] scaled;
   logic [PROD_W-1:0]   product;
   logic [FILL_W-1:0]   eff_len;
   logic                drop;
   logic [IDX_W-1:0]    oldest_wide;
   logic [TIME_W-1:0]   elapsed;
   logic [FILL_W:0]     div_shift;
   logic                div_ge;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_GATE;
         end
         ST_GATE: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done && out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      gate_en   = 1'b0;
      div_busy  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_GATE: begin
            gate_en = 1'b1;
         end
         ST_DIVIDE: begin
            div_busy = !div_done;
            out_load = div_done && out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept   = req_valid && !req_stall;
   assign div_done = (cnt_ff == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // configuration writes
   always_comb begin
      min_dist_in = min_dist_ff;
      max_dist_in = max_dist_ff;
      hold_win_in = hold_win_ff;
      win_len_in  = win_len_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_DIST:    min_dist_in = csr_wdata;
            CSR_MAX_DIST:    max_dist_in = csr_wdata;
            CSR_HOLD_WINDOW: hold_win_in = csr_wdata;
            CSR_WIN_LEN:     win_len_in  = csr_wdata[WIN_LEN_W-1:0];
            default:         min_dist_in = min_dist_ff;
         endcase
      end
   end

   // echo to millimetres: floor(echo * 17 / 100) by reciprocal multiply
   assign scaled  = SCALED_W'({req_data.echo_us, 4'b0000}) + SCALED_W'(req_data.echo_us);
   assign product = PROD_W'(scaled) * PROD_W'(RECIP_100);

   always_comb begin
      raw_in = raw_ff;
      now_in = now_ff;
      if (accept) begin
         raw_in = product[RECIP_SHIFT +: DIST_W];
         now_in = req_data.now_ms;
      end
   end

   // effective window length and oldest entry address
   always_comb begin
      if (win_len_ff == '0) begin
         eff_len = FILL_W'(1);
      end else if (int'(win_len_ff) > MAX_WINDOW) begin
         eff_len = FILL_W'(MAX_WINDOW);
      end else begin
         eff_len = FILL_W'(win_len_ff);
      end
      drop        = (fill_ff >= eff_len);
      oldest_wide = IDX_W'(head_ff) + IDX_W'(MAX_WINDOW) - IDX_W'(fill_ff);
      if (oldest_wide >= IDX_W'(MAX_WINDOW)) begin
         oldest_wide = oldest_wide - IDX_W'(MAX_WINDOW);
      end
      rd_addr = oldest_wide[PTR_W-1:0];
   end

   // range gating, hold timer and trigger flag
   assign elapsed = now_ff - hold_start_ff;

   always_comb begin
      gated         = ((raw_ff >= DIST_W'(min_dist_ff)) && (raw_ff <= DIST_W'(max_dist_ff)))
                      ? raw_ff : '0;
      hold_start_in = hold_start_ff;
      trig_in       = trig_ff;
      prev_raw_in   = prev_raw_ff;
      if (gate_en) begin
         prev_raw_in = raw_ff;
         if (prev_raw_ff == '0) begin
            hold_start_in = now_ff;
            if (raw_ff == '0) begin
               gated   = '0;
               trig_in = 1'b0;
            end
         end else if (elapsed > TIME_W'(hold_win_ff)) begin
            gated   = raw_ff;
            trig_in = 1'b0;
         end else if ((raw_ff == '0) && (prev_out_ff != '0)) begin
            trig_in = 1'b1;
         end
      end
   end

   // window update: drop oldest if full, push gated value
   always_comb begin
      sum_in  = sum_ff;
      fill_in = fill_ff;
      head_in = head_ff;
      if (gate_en) begin
         sum_in  = sum_ff - (drop ? SUM_W'(rd_data_ff) : '0) + SUM_W'(gated);
         fill_in = drop ? fill_ff : fill_ff + FILL_W'(1);
         head_in = (head_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : head_ff + PTR_W'(1);
      end
   end

   // restoring divider: sum / fill, one quotient bit a cycle
   assign div_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge    = (div_shift >= {1'b0, fill_ff});

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (gate_en) begin
         quo_in = sum_in;
         rem_in = '0;
         cnt_in = CNT_W'(SUM_W);
      end else if (div_busy) begin
         rem_in = div_ge ? FILL_W'(div_shift - {1'b0, fill_ff}) : div_shift[FILL_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], div_ge};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // output register and average history
   always_comb begin
      prev_out_in  = prev_out_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         prev_out_in             = quo_ff[DIST_W-1:0];
         rsp_data_in.distance_mm = quo_ff[DIST_W-1:0];
         rsp_data_in.trigger     = trig_ff;
         rsp_valid_in            = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // window memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (gate_en) begin
         window_mem[head_ff] <= gated;
      end
      rd_data_ff <= window_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_dist_ff   <= MIN_DIST_RST;
         max_dist_ff   <= MAX_DIST_RST;
         hold_win_ff   <= HOLD_WINDOW_RST;
         win_len_ff    <= WIN_LEN_RST;
         prev_raw_ff   <= '0;
         hold_start_ff <= '0;
         prev_out_ff   <= '0;
         trig_ff       <= 1'b0;
         fill_ff       <= '0;
         head_ff       <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         min_dist_ff   <= min_dist_in;
         max_dist_ff   <= max_dist_in;
         hold_win_ff   <= hold_win_in;
         win_len_ff    <= win_len_in;
         prev_raw_ff   <= prev_raw_in;
         hold_start_ff <= hold_start_in;
         prev_out_ff   <= prev_out_in;
         trig_ff       <= trig_in;
         fill_ff       <= fill_in;
         head_ff       <= head_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      now_ff      <= now_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
